// ===== rtl/filtered_lexicographic_best_select_macros.svh =====
// Assertion macros used by the goal selector top level.
`ifndef FILTERED_LEXICOGRAPHIC_BEST_SELECT_MACROS_SVH
`define FILTERED_LEXICOGRAPHIC_BEST_SELECT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FLBS_ASSERT_IMPLIES(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Condition that must never be true outside reset.
`define FLBS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/flbs_pkg.sv =====
// Shared types and constants of the goal selector.
package flbs_pkg;

    localparam int unsigned MAX_PRIORITY = 10000;

    localparam int unsigned ID_W   = 64;
    localparam int unsigned PRIO_W = 14;
    localparam int unsigned MINP_W = 16;
    localparam int unsigned HOR_W  = 3;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned CIDX_W = 3;

    // goal status codes
    localparam logic [STAT_W-1:0] STATUS_PLANNED = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_ACTIVE  = 2'd1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_OWNER_ID      = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_MIN_PRIORITY  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_ALLOW_PLANNED = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_ALLOW_ACTIVE  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_PREF_HORIZON  = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]   owner_id;
        logic [MINP_W-1:0] min_priority;
        logic              allow_planned;
        logic              allow_active;
        logic [HOR_W-1:0]  preferred_horizon;
    } flbs_cfg_t;

    // one classified record as it travels from front to back
    typedef struct packed {
        logic              qual;
        logic              last;
        logic [ID_W-1:0]   ident;
        logic [PRIO_W-1:0] prio;
        logic [HOR_W-1:0]  horizon;
        logic              active;
        logic [ID_W-1:0]   created;
    } flbs_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } flbs_qstat_t;

endpackage

// ===== rtl/flbs_if.sv =====
// Channel interfaces of the goal selector: config write, goal input, result output.
interface flbs_cfg_if
    import flbs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [ID_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface flbs_goal_if
    import flbs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   goal_owner;
    logic [ID_W-1:0]   goal_ident;
    logic [PRIO_W-1:0] goal_priority;
    logic [HOR_W-1:0]  goal_horizon;
    logic [STAT_W-1:0] goal_status;
    logic [ID_W-1:0]   goal_created;
    logic              last_goal;

    modport source (output valid, output goal_owner, output goal_ident,
                    output goal_priority, output goal_horizon, output goal_status,
                    output goal_created, output last_goal, input ready);
    modport sink   (input valid, input goal_owner, input goal_ident,
                    input goal_priority, input goal_horizon, input goal_status,
                    input goal_created, input last_goal, output ready);
endinterface

interface flbs_result_if
    import flbs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              found;
    logic [ID_W-1:0]   best_ident;
    logic [PRIO_W-1:0] best_prio;
    logic [HOR_W-1:0]  best_horizon_out;
    logic              best_status;
    logic [ID_W-1:0]   best_created_out;

    modport source (output valid, output found, output best_ident, output best_prio,
                    output best_horizon_out, output best_status,
                    output best_created_out, input ready);
    modport sink   (input valid, input found, input best_ident, input best_prio,
                    input best_horizon_out, input best_status,
                    input best_created_out, output ready);
endinterface

// ===== rtl/flbs_front.sv =====
// Front end: accepts goal records and runs the qualification filter.
module flbs_front
    import flbs_pkg::*;
(
    flbs_goal_if.sink   goal,
    input  flbs_cfg_t   cfg_q,
    input  flbs_qstat_t q_stat,
    output logic        push,
    output flbs_entry_t push_entry
);

    logic owner_ok;
    logic prio_ok;
    logic status_ok;
    logic accept;

    always_comb
    begin
        owner_ok  = (cfg_q.owner_id != '0) && (goal.goal_owner == cfg_q.owner_id);
        prio_ok   = (cfg_q.min_priority <= MINP_W'(MAX_PRIORITY))
                    && ({{(MINP_W-PRIO_W){1'b0}}, goal.goal_priority}
                        >= cfg_q.min_priority);
        status_ok = ((goal.goal_status == STATUS_PLANNED) && cfg_q.allow_planned)
                    || ((goal.goal_status == STATUS_ACTIVE) && cfg_q.allow_active);
    end

    assign goal.ready = !q_stat.full;
    assign accept     = goal.valid && goal.ready;

    always_comb
    begin
        push_entry.qual    = owner_ok && prio_ok && status_ok;
        push_entry.last    = goal.last_goal;
        push_entry.ident   = goal.goal_ident;
        push_entry.prio    = goal.goal_priority;
        push_entry.horizon = goal.goal_horizon;
        push_entry.active  = (goal.goal_status == STATUS_ACTIVE);
        push_entry.created = goal.goal_created;
    end

    // records that neither qualify nor close a list are dropped here
    assign push = accept && (push_entry.qual || push_entry.last);

endmodule

// ===== rtl/flbs_fifo.sv =====
// Short queue between front and back end.
module flbs_fifo
    import flbs_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  flbs_entry_t push_entry,
    input  logic        pop,
    output flbs_entry_t pop_entry,
    output flbs_qstat_t q_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    flbs_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    assign pop_entry    = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

// ===== rtl/flbs_back.sv =====
// Back end: running best compare and result register.
module flbs_back
    import flbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [HOR_W-1:0]  pref_horizon,
    input  flbs_qstat_t       q_stat,
    input  flbs_entry_t       head,
    output logic              pop,
    flbs_result_if.source     result
);

    logic              have_best_reg, have_best_next;
    logic [ID_W-1:0]   held_ident_reg, held_ident_next;
    logic [PRIO_W-1:0] held_prio_reg, held_prio_next;
    logic [HOR_W-1:0]  held_hor_reg, held_hor_next;
    logic              held_act_reg, held_act_next;
    logic [ID_W-1:0]   held_created_reg, held_created_next;

    logic              out_valid_reg;
    logic              out_found_reg;
    logic [ID_W-1:0]   out_ident_reg;
    logic [PRIO_W-1:0] out_prio_reg;
    logic [HOR_W-1:0]  out_hor_reg;
    logic              out_status_reg;
    logic [ID_W-1:0]   out_created_reg;

    logic [HOR_W-1:0] cand_gap;
    logic [HOR_W-1:0] held_gap;
    logic             beats;
    logic             take;

    function automatic logic [HOR_W-1:0] gap(input logic [HOR_W-1:0] h,
                                             input logic [HOR_W-1:0] p);
        return (h > p) ? h - p : p - h;
    endfunction

    always_comb
    begin
        cand_gap = gap(head.horizon, pref_horizon);
        held_gap = gap(held_hor_reg, pref_horizon);
        if (head.prio != held_prio_reg)
            beats = head.prio > held_prio_reg;
        else if (cand_gap != held_gap)
            beats = cand_gap < held_gap;
        else if (head.active != held_act_reg)
            beats = head.active;
        else if (head.created != held_created_reg)
            beats = head.created < held_created_reg;
        else
            beats = head.ident < held_ident_reg;
    end

    // a list end waits only while the result register is still occupied
    assign pop  = !q_stat.empty && (!head.last || !out_valid_reg || result.ready);
    assign take = pop && head.qual && (!have_best_reg || beats);

    always_comb
    begin
        have_best_next    = have_best_reg || take;
        held_ident_next   = take ? head.ident   : held_ident_reg;
        held_prio_next    = take ? head.prio    : held_prio_reg;
        held_hor_next     = take ? head.horizon : held_hor_reg;
        held_act_next     = take ? head.active  : held_act_reg;
        held_created_next = take ? head.created : held_created_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && head.last)
            begin
                have_best_reg <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                have_best_reg <= have_best_next;
                if (result.ready)
                    out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        held_ident_reg   <= held_ident_next;
        held_prio_reg    <= held_prio_next;
        held_hor_reg     <= held_hor_next;
        held_act_reg     <= held_act_next;
        held_created_reg <= held_created_next;
        if (pop && head.last)
        begin
            out_found_reg   <= have_best_next;
            out_ident_reg   <= have_best_next ? held_ident_next   : '0;
            out_prio_reg    <= have_best_next ? held_prio_next    : '0;
            out_hor_reg     <= have_best_next ? held_hor_next     : '0;
            out_status_reg  <= have_best_next ? held_act_next     : 1'b0;
            out_created_reg <= have_best_next ? held_created_next : '0;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.found            = out_found_reg;
    assign result.best_ident       = out_ident_reg;
    assign result.best_prio        = out_prio_reg;
    assign result.best_horizon_out = out_hor_reg;
    assign result.best_status      = out_status_reg;
    assign result.best_created_out = out_created_reg;

endmodule

// ===== rtl/filtered_lexicographic_best_select.sv =====
// A list-closing record goes from a queue slot into the result register when popped.
// Throughput: one goal record per cycle while the queue is not full; the back end's
//   single compare against the held best retires one queue entry per cycle, and
//   stalls only while a list end waits in the queue for the previous result to be taken.
// Reset (rst_n low, async): queue empty, no held best, no result pending,
//   owner 0, min priority 0, planned and active allowed, preferred horizon 0.
`include "filtered_lexicographic_best_select_macros.svh"

module filtered_lexicographic_best_select
    import flbs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)(
    input  logic         clk,
    input  logic         rst_n,
    flbs_cfg_if.sink     cfg,
    flbs_goal_if.sink    goal,
    flbs_result_if.source result
);

    // configuration registers; the user is to write them only while the block is idle (not enforced by the block)
    flbs_cfg_t cfg_reg, cfg_next;

    flbs_entry_t push_entry;
    flbs_entry_t head;
    flbs_qstat_t q_stat;
    logic        push;
    logic        pop;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_OWNER_ID:      cfg_next.owner_id          = cfg.data;
                CFG_MIN_PRIORITY:  cfg_next.min_priority      = cfg.data[MINP_W-1:0];
                CFG_ALLOW_PLANNED: cfg_next.allow_planned     = cfg.data[0];
                CFG_ALLOW_ACTIVE:  cfg_next.allow_active      = cfg.data[0];
                CFG_PREF_HORIZON:  cfg_next.preferred_horizon = cfg.data[HOR_W-1:0];
                default:           cfg_next = cfg_reg;   // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.owner_id          <= '0;
            cfg_reg.min_priority      <= '0;
            cfg_reg.allow_planned     <= 1'b1;
            cfg_reg.allow_active      <= 1'b1;
            cfg_reg.preferred_horizon <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: filter and classify each accepted transaction
    flbs_front u_front (
        .goal       (goal),
        .cfg_q      (cfg_reg),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    // queue decouples input acceptance from result backpressure
    flbs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (head),
        .q_stat     (q_stat)
    );

    // back: lexicographic compare against the held best, result register
    flbs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pref_horizon (cfg_reg.preferred_horizon),
        .q_stat       (q_stat),
        .head         (head),
        .pop          (pop),
        .result       (result)
    );

    // no winner means all result fields read zero
    `FLBS_ASSERT_IMPLIES(a_nofound_zero, result.valid && !result.found,
        (result.best_ident == '0) && (result.best_prio == '0) &&
        (result.best_horizon_out == '0) && !result.best_status &&
        (result.best_created_out == '0), "empty result carries nonzero fields")
    // queue flags are exclusive
    `FLBS_ASSERT_NEVER(a_q_flags, q_stat.full && q_stat.empty, "queue full and empty")
    // a new result only comes out of a popped list end
    `FLBS_ASSERT_IMPLIES(a_result_src, $rose(result.valid), $past(pop && head.last),
        "result raised without a list end")
    // the back end never pops an empty queue
    `FLBS_ASSERT_IMPLIES(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")

endmodule

// ===== bench/filtered_lexicographic_best_select_test.sv =====
// Testbench for the goal selector: directed plan, random lists, self-checking predictor.
module filtered_lexicographic_best_select_test
    import flbs_pkg::*;
;

    // status codes the block treats as ineligible
    localparam logic [STAT_W-1:0] STATUS_OTHER = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_SPARE = 2'd3;
    // register index with no register behind it
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam logic [ID_W-1:0] ALL_ONES = '1;

    localparam int SETTLE_CYCLES   = 8;     // back end retires queued records
    localparam int HOLD_CYCLES     = 150;   // long result hold-off
    localparam int STALL_LIMIT     = 1000;  // cycles without any transaction
    localparam int PHASES          = 20;
    localparam int ITEMS_PER_PHASE = 50;

    typedef struct packed {
        logic [ID_W-1:0]   owner;
        logic [ID_W-1:0]   ident;
        logic [PRIO_W-1:0] prio;
        logic [HOR_W-1:0]  horizon;
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   created;
        logic              last;
    } goal_rec_t;

    // doubles as the held best (found = have_best) and as one result
    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   ident;
        logic [PRIO_W-1:0] prio;
        logic [HOR_W-1:0]  horizon;
        logic              active;
        logic [ID_W-1:0]   created;
    } verdict_t;

    localparam verdict_t NO_WINNER = '0;

    typedef enum bit {ROW_GOAL, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [CIDX_W-1:0] idx;
        logic [ID_W-1:0]   val;
        goal_rec_t         rec;
        bit                typed;   // want was written by hand
        verdict_t          want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    flbs_cfg_if    cfg_ch ();
    flbs_goal_if   goal_ch ();
    flbs_result_if res_ch ();

    filtered_lexicographic_best_select dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .goal   (goal_ch),
        .result (res_ch)
    );

    // predictor state: register shadow and the running best
    flbs_cfg_t filt;
    verdict_t  held = '0;

    verdict_t  due_winners[$];   // list results owed by the block, oldest first
    plan_row_t plan[$];
    int        mismatches = 0;
    bit        send_eager = 1'b0;  // sender offers back to back

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [HOR_W-1:0] horizon_gap(input logic [HOR_W-1:0] a,
                                                     input logic [HOR_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Fold one record into the running best. Returns 1 on a list end, with the
    // winner (or all zeros) in v, and clears the running best.
    function automatic bit fold_into_best(input goal_rec_t g, output verdict_t v);
        logic [HOR_W-1:0] gap_new;
        logic [HOR_W-1:0] gap_old;
        bit               act;
        bit               ok;
        bit               wins;
        v   = NO_WINNER;
        act = (g.status == STATUS_ACTIVE);
        ok  = filt.owner_id != '0 && filt.min_priority <= MAX_PRIORITY
              && g.owner == filt.owner_id && g.prio >= filt.min_priority
              && ((g.status == STATUS_PLANNED && filt.allow_planned)
                  || (act && filt.allow_active));
        // held distance is taken against the current preferred horizon
        gap_new = horizon_gap(g.horizon, filt.preferred_horizon);
        gap_old = horizon_gap(held.horizon, filt.preferred_horizon);
        if (!held.found)
            wins = 1'b1;
        else if (g.prio != held.prio)
            wins = g.prio > held.prio;
        else if (gap_new != gap_old)
            wins = gap_new < gap_old;
        else if (act != held.active)
            wins = act;
        else if (g.created != held.created)
            wins = g.created < held.created;
        else
            wins = g.ident < held.ident;   // exact tie keeps the earlier record
        if (ok && wins)
            held = '{1'b1, g.ident, g.prio, g.horizon, act, g.created};
        if (!g.last)
            return 1'b0;
        v    = held;
        held = '0;
        return 1'b1;
    endfunction

    function automatic plan_row_t goal_row(input logic [ID_W-1:0] owner,
                                           input logic [ID_W-1:0] ident,
                                           input logic [PRIO_W-1:0] prio,
                                           input logic [HOR_W-1:0] hor,
                                           input logic [STAT_W-1:0] st,
                                           input logic [ID_W-1:0] created,
                                           input bit last);
        plan_row_t r;
        r       = '{kind: ROW_GOAL, typed: 1'b0, default: '0};
        r.rec   = '{owner, ident, prio, hor, st, created, last};
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [CIDX_W-1:0] idx,
                                          input logic [ID_W-1:0] val);
        plan_row_t r;
        r     = '{kind: ROW_REG, typed: 1'b0, default: '0};
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic plan_row_t expecting(input plan_row_t r, input verdict_t w);
        r.typed = 1'b1;
        r.want  = w;
        return r;
    endfunction

    // Mostly the configured owner, a few near misses and strangers; small pools
    // for ident, created and high priorities so that ties get exercised.
    function automatic goal_rec_t random_goal();
        goal_rec_t r;
        case ($urandom_range(0, 7))
            0:       r.owner = {$urandom, $urandom};
            1:       r.owner = filt.owner_id ^ (64'd1 << $urandom_range(0, 63));
            default: r.owner = filt.owner_id;
        endcase
        r.ident = $urandom_range(0, 1) ? {$urandom, $urandom} : ID_W'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0:          r.prio = PRIO_W'($urandom);
            1, 2, 3:    r.prio = $urandom_range(0, MAX_PRIORITY);
            default:    r.prio = $urandom_range(MAX_PRIORITY - 4, MAX_PRIORITY);
        endcase
        r.horizon = HOR_W'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: r.status = STATUS_PLANNED;
            4, 5, 6, 7: r.status = STATUS_ACTIVE;
            8:          r.status = STATUS_OTHER;
            default:    r.status = STATUS_SPARE;
        endcase
        r.created = $urandom_range(0, 1) ? {$urandom, $urandom}
                                         : ID_W'($urandom_range(0, 3));
        r.last    = 1'b0;
        return r;
    endfunction

    // One goal transaction; valid stays high afterwards for a back-to-back item.
    task automatic send_goal(input goal_rec_t r, input bit typed, input verdict_t want);
        int       gap;
        verdict_t v;
        gap = send_eager ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            goal_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        goal_ch.valid         <= 1'b1;
        goal_ch.goal_owner    <= r.owner;
        goal_ch.goal_ident    <= r.ident;
        goal_ch.goal_priority <= r.prio;
        goal_ch.goal_horizon  <= r.horizon;
        goal_ch.goal_status   <= r.status;
        goal_ch.goal_created  <= r.created;
        goal_ch.last_goal     <= r.last;
        do @(posedge clk); while (!goal_ch.ready);
        if (fold_into_best(r, v))
            due_winners.push_back(typed ? want : v);
    endtask

    // Register write; the shadow copy follows on the accepting edge.
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [ID_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_OWNER_ID:      filt.owner_id          = val;
            CFG_MIN_PRIORITY:  filt.min_priority      = val[MINP_W-1:0];
            CFG_ALLOW_PLANNED: filt.allow_planned     = val[0];
            CFG_ALLOW_ACTIVE:  filt.allow_active      = val[0];
            CFG_PREF_HORIZON:  filt.preferred_horizon = val[HOR_W-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering goals, wait for every owed result, then let records that
    // close no list clear the back end.
    task automatic drain_results();
        goal_ch.valid <= 1'b0;
        do @(posedge clk); while (due_winners.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string what, input logic [ID_W-1:0] want,
                               input logic [ID_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Result checker: every taken result against the oldest owed one.
    always @(posedge clk)
    begin : winner_check
        verdict_t w;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (due_winners.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual found=%0b ident=%0h",
                         $time, res_ch.found, res_ch.best_ident);
                mismatches++;
            end
            else
            begin
                w = due_winners.pop_front();
                check_field("found", w.found, res_ch.found);
                check_field("best_ident", w.ident, res_ch.best_ident);
                check_field("best_prio", w.prio, res_ch.best_prio);
                check_field("best_horizon_out", w.horizon, res_ch.best_horizon_out);
                check_field("best_status", w.active, res_ch.best_status);
                check_field("best_created_out", w.created, res_ch.best_created_out);
            end
        end
    end

    // Result taker: random stalls, runs with none, and two long hold-offs during
    // which the sender keeps pushing so the queue fills and goal ready drops.
    initial
    begin : result_taker
        int gap;
        int taken;
        bit eager;
        taken = 0;
        eager = 1'b0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                eager = !eager;
            gap = eager ? 0 : $urandom_range(0, 6);
            if (taken == 30 || taken == 150)
                gap = HOLD_CYCLES;
            if (gap != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            taken++;
        end
    end

    // Watchdog: any transaction on any channel resets the count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cfg_ch.valid && cfg_ch.ready) || (goal_ch.valid && goal_ch.ready)
                || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** filtered_lexicographic_best_select: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int               sent;
        int               len;
        logic [ID_W-1:0]  junk;
        logic [ID_W-1:0]  pick;
        logic [MINP_W-1:0] floor_pick;
        goal_rec_t        r;

        filt = '{owner_id: '0, min_priority: '0, allow_planned: 1'b1,
                 allow_active: 1'b1, preferred_horizon: '0};

        rst_n                 <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= '0;
        cfg_ch.data           <= '0;
        goal_ch.valid         <= 1'b0;
        goal_ch.goal_owner    <= '0;
        goal_ch.goal_ident    <= '0;
        goal_ch.goal_priority <= '0;
        goal_ch.goal_horizon  <= '0;
        goal_ch.goal_status   <= STATUS_PLANNED;
        goal_ch.goal_created  <= '0;
        goal_ch.last_goal     <= 1'b0;

        // ---- directed plan ----
        // out of reset the owner is zero: nothing qualifies, even owner zero goals
        plan.push_back(expecting(goal_row('0, 1, 100, 0, STATUS_PLANNED, 5, 1), NO_WINNER));
        plan.push_back(reg_row(CFG_OWNER_ID, ALL_ONES));
        // field extremes, priority beyond its range kept as the raw value
        plan.push_back(expecting(goal_row(ALL_ONES, ALL_ONES, 14'h3FFF, 7, STATUS_ACTIVE,
                                          ALL_ONES, 1),
                                 '{1'b1, ALL_ONES, 14'h3FFF, 3'd7, 1'b1, ALL_ONES}));
        plan.push_back(expecting(goal_row(ALL_ONES, 0, 0, 0, STATUS_PLANNED, 0, 1),
                                 '{1'b1, '0, '0, '0, 1'b0, '0}));
        // both ineligible status codes
        plan.push_back(expecting(goal_row(ALL_ONES, 9, 50, 1, STATUS_OTHER, 3, 1), NO_WINNER));
        plan.push_back(expecting(goal_row(ALL_ONES, 9, 50, 1, STATUS_SPARE, 3, 1), NO_WINNER));
        // ranking ladder: horizon distance, active, older, smaller id, exact tie,
        // lower priority, foreign owner, then a higher priority closes the list
        plan.push_back(goal_row(ALL_ONES, 20, 500, 3, STATUS_PLANNED, 10, 0));
        plan.push_back(goal_row(ALL_ONES, 21, 500, 0, STATUS_PLANNED, 10, 0));
        plan.push_back(goal_row(ALL_ONES, 22, 500, 0, STATUS_ACTIVE, 10, 0));
        plan.push_back(goal_row(ALL_ONES, 23, 500, 0, STATUS_ACTIVE, 9, 0));
        plan.push_back(goal_row(ALL_ONES, 5, 500, 0, STATUS_ACTIVE, 9, 0));
        plan.push_back(goal_row(ALL_ONES, 5, 500, 0, STATUS_ACTIVE, 9, 0));
        plan.push_back(goal_row(ALL_ONES, 1, 499, 0, STATUS_ACTIVE, 0, 0));
        plan.push_back(goal_row(64'd1, 2, 9999, 0, STATUS_ACTIVE, 0, 0));
        plan.push_back(goal_row(ALL_ONES, 6, 501, 7, STATUS_PLANNED, ALL_ONES, 1));
        // minimum above the maximum priority selects nothing
        plan.push_back(reg_row(CFG_MIN_PRIORITY, MAX_PRIORITY + 1));
        plan.push_back(expecting(goal_row(ALL_ONES, 7, 10000, 0, STATUS_ACTIVE, 0, 1),
                                 NO_WINNER));
        plan.push_back(reg_row(CFG_MIN_PRIORITY, 16'hFFFF));
        plan.push_back(expecting(goal_row(ALL_ONES, 7, 10000, 0, STATUS_ACTIVE, 0, 1),
                                 NO_WINNER));
        // minimum at the maximum: a priority just below fails, the maximum itself passes
        plan.push_back(reg_row(CFG_MIN_PRIORITY, MAX_PRIORITY));
        plan.push_back(goal_row(ALL_ONES, 8, 9999, 0, STATUS_ACTIVE, 0, 0));
        plan.push_back(expecting(goal_row(ALL_ONES, 9, 10000, 2, STATUS_PLANNED, 1, 1),
                                 '{1'b1, 64'd9, 14'd10000, 3'd2, 1'b0, 64'd1}));
        // planned blocked, then active blocked
        plan.push_back(reg_row(CFG_MIN_PRIORITY, 0));
        plan.push_back(reg_row(CFG_ALLOW_PLANNED, 0));
        plan.push_back(goal_row(ALL_ONES, 10, 9000, 0, STATUS_PLANNED, 0, 0));
        plan.push_back(expecting(goal_row(ALL_ONES, 11, 100, 5, STATUS_ACTIVE, 4, 1),
                                 '{1'b1, 64'd11, 14'd100, 3'd5, 1'b1, 64'd4}));
        plan.push_back(reg_row(CFG_ALLOW_PLANNED, 1));
        plan.push_back(reg_row(CFG_ALLOW_ACTIVE, 0));
        plan.push_back(goal_row(ALL_ONES, 12, 9000, 0, STATUS_ACTIVE, 0, 0));
        plan.push_back(expecting(goal_row(ALL_ONES, 13, 100, 6, STATUS_PLANNED, 2, 1),
                                 '{1'b1, 64'd13, 14'd100, 3'd6, 1'b0, 64'd2}));
        // write to an index with no register: no effect
        plan.push_back(reg_row(CFG_ALLOW_ACTIVE, 1));
        plan.push_back(reg_row(CFG_UNUSED, ALL_ONES));
        // preferred horizon moves mid-list; the held record is re-ranked against it
        plan.push_back(reg_row(CFG_PREF_HORIZON, 7));
        plan.push_back(goal_row(ALL_ONES, 14, 300, 7, STATUS_PLANNED, 0, 0));
        plan.push_back(reg_row(CFG_PREF_HORIZON, 0));
        plan.push_back(goal_row(ALL_ONES, 15, 300, 1, STATUS_PLANNED, 0, 1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                drain_results();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
                send_goal(plan[i].rec, plan[i].typed, plan[i].want);
        end

        // ---- random phases: new settings, then lists of random length ----
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            // narrow registers sometimes get junk in the unused upper bits
            junk = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
            case ($urandom_range(0, 7))
                0:       pick = '0;
                1:       pick = ALL_ONES;
                2:       pick = 64'd1;
                default: pick = {$urandom, $urandom};
            endcase
            write_reg(CFG_OWNER_ID, pick);
            case ($urandom_range(0, 7))
                0:       floor_pick = $urandom_range(MAX_PRIORITY + 1, 16'hFFFF);
                1:       floor_pick = MAX_PRIORITY;
                2:       floor_pick = $urandom_range(MAX_PRIORITY - 10, MAX_PRIORITY);
                default: floor_pick = $urandom_range(0, 6000);
            endcase
            write_reg(CFG_MIN_PRIORITY, {junk[ID_W-1:MINP_W], floor_pick});
            write_reg(CFG_ALLOW_PLANNED, {junk[ID_W-1:1], ($urandom_range(0, 3) != 0)});
            write_reg(CFG_ALLOW_ACTIVE, {junk[ID_W-1:1], ($urandom_range(0, 3) != 0)});
            write_reg(CFG_PREF_HORIZON, {junk[ID_W-1:HOR_W], HOR_W'($urandom)});

            send_eager = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                begin
                    r      = random_goal();
                    r.last = (k == len - 1);
                    send_goal(r, 1'b0, NO_WINNER);
                end
                sent += len;
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("** filtered_lexicographic_best_select: PASSED **");
        else
            $display("** filtered_lexicographic_best_select: FAILED **");
        $finish;
    end

endmodule
